>>> design/fpm_pkg.sv
package fpm_pkg;

	// frame length limit and the widths that follow from it
	localparam int MAX_FRAME = 4096;
	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	localparam int SAMPLE_W = 16;
	localparam int MAG_W = 16;
	localparam int SUM_W = 43;
	localparam int LEVEL_W = 16;
	localparam int ROOT_W = 16;
	localparam int MEAN_W = 31;
	localparam int PROD_W = 32;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int BIT_IDX_W = $clog2(ROOT_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
	localparam logic [LEVEL_W:0] FULL_SCALE = 17'd32768;
	localparam logic [MEAN_W-1:0] MEAN_MAX = 31'd1073741824;

	// smoothing and decay coefficients, q0.16
	localparam logic [15:0] K_RMS_OLD = 16'd51118;
	localparam logic [15:0] K_RMS_NEW = 16'd14418;
	localparam logic [15:0] K_PEAK_DECAY = 16'd53740;
	localparam logic [PROD_W:0] HALF_Q16 = 33'd32768;

	// what the front hands over for one finished frame
	typedef struct packed {
		logic [SUM_W-1:0] square_sum;
		logic [CNT_W-1:0] count;
		logic [MAG_W-1:0] peak;
		logic             overlong;
	} fpm_frame_t;

endpackage

>>> design/fpm_in_if.sv
interface fpm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink (input valid, input sample, input frame_end, output ready);
endinterface

>>> design/fpm_out_if.sv
interface fpm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level_rms;
	logic [15:0] level_peak;
	logic        frame_overlong;

	modport source (output valid, output level_rms, output level_peak,
		output frame_overlong, input ready);
	modport sink (input valid, input level_rms, input level_peak,
		input frame_overlong, output ready);
endinterface

>>> design/fpm_front.sv
module fpm_front (
	input  logic               clk,
	input  logic               arst_n,
	fpm_in_if.sink             audio,
	output logic               push_valid,
	input  logic               push_ready,
	output fpm_pkg::fpm_frame_t push_frame
);
	import fpm_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic [MAG_W-1:0] peak_q;
	logic             overlong_q;

	logic             accept;
	logic [MAG_W-1:0] mag;
	logic [PROD_W-1:0] square;
	logic [SUM_W:0]   sum_add;
	logic             full;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] count_next;
	logic [MAG_W-1:0] peak_next;
	logic             overlong_next;

	assign audio.ready = push_ready;
	assign accept = audio.valid && push_ready;

	always_comb begin
		// two's complement magnitude, -32768 gives 32768 which still fits
		mag = audio.sample[SAMPLE_W-1] ? MAG_W'(~audio.sample + 16'sd1)
			: MAG_W'(audio.sample);
		square = PROD_W'(mag) * PROD_W'(mag);
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(square);
		full = (count_q >= CNT_W'(MAX_FRAME));
		peak_next = (mag > peak_q) ? mag : peak_q;
		if (full) begin
			sum_next = sum_q;
			count_next = count_q;
			overlong_next = 1'b1;
		end else begin
			sum_next = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
			count_next = count_q + CNT_W'(1);
			overlong_next = overlong_q;
		end
	end

	assign push_valid = accept && audio.frame_end;
	assign push_frame = '{square_sum: sum_next, count: count_next, peak: peak_next,
		overlong: overlong_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			peak_q <= '0;
			overlong_q <= 1'b0;
		end else if (accept) begin
			if (audio.frame_end) begin
				sum_q <= '0;
				count_q <= '0;
				peak_q <= '0;
				overlong_q <= 1'b0;
			end else begin
				sum_q <= sum_next;
				count_q <= count_next;
				peak_q <= peak_next;
				overlong_q <= overlong_next;
			end
		end
	end

endmodule

>>> design/fpm_queue.sv
module fpm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  fpm_pkg::fpm_frame_t push_frame,
	output logic               pop_valid,
	input  logic               pop_ready,
	output fpm_pkg::fpm_frame_t pop_frame
);
	import fpm_pkg::*;

	fpm_frame_t       entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_frame = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

>>> design/fpm_back.sv
module fpm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  fpm_pkg::fpm_frame_t pop_frame,
	fpm_out_if.source          meter
);
	import fpm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_ROOT  = 7'b0000100,
		ST_FIX   = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_BLEND = 7'b1000000
	} back_state_t;

	back_state_t          state_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     divisor_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [ROOT_W-1:0]    root_q;
	logic [BIT_IDX_W-1:0] bit_idx_q;
	logic [PROD_W-1:0]    sq_q;
	logic [LEVEL_W-1:0]   rms_new_q;
	logic [MAG_W-1:0]     frame_peak_q;
	logic                 overlong_q;
	logic [PROD_W-1:0]    prod_old_q;
	logic [PROD_W-1:0]    prod_new_q;
	logic [PROD_W-1:0]    prod_peak_q;
	logic [LEVEL_W-1:0]   smooth_rms_q;
	logic [LEVEL_W-1:0]   smooth_peak_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_rms_q;
	logic [LEVEL_W-1:0]   out_peak_q;
	logic                 out_overlong_q;

	logic [CNT_W:0]       rem_sh;
	logic                 q_bit;
	logic [CNT_W:0]       rem_sub;
	logic [SUM_W-1:0]     quo_next;
	logic [ROOT_W-1:0]    trial;
	logic [PROD_W-1:0]    trial_sq;
	logic [MEAN_W-1:0]    diff;
	logic [LEVEL_W:0]     root_rnd;
	logic [PROD_W:0]      rms_acc;
	logic [PROD_W:0]      peak_acc;
	logic [LEVEL_W:0]     rms_cand;
	logic [LEVEL_W:0]     decayed;
	logic [LEVEL_W:0]     peak_cand;
	logic                 out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || meter.ready;

	always_comb begin
		// restoring divide step
		rem_sh = {rem_q, quo_q[SUM_W-1]};
		q_bit = (rem_sh >= {1'b0, divisor_q});
		rem_sub = q_bit ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
		quo_next = {quo_q[SUM_W-2:0], q_bit};
		// square root trial bit
		trial = root_q | (ROOT_W'(1) << bit_idx_q);
		trial_sq = PROD_W'(trial) * PROD_W'(trial);
		// round to nearest and hold at full scale
		diff = mean_q - sq_q[MEAN_W-1:0];
		root_rnd = (diff > MEAN_W'(root_q)) ? ((LEVEL_W + 1)'(root_q) + (LEVEL_W + 1)'(1))
			: (LEVEL_W + 1)'(root_q);
		// smoothing
		rms_acc = (PROD_W + 1)'(prod_old_q) + (PROD_W + 1)'(prod_new_q) + HALF_Q16;
		peak_acc = (PROD_W + 1)'(prod_peak_q) + HALF_Q16;
		rms_cand = rms_acc[PROD_W:16];
		decayed = peak_acc[PROD_W:16];
		peak_cand = (decayed > (LEVEL_W + 1)'(frame_peak_q)) ? decayed
			: (LEVEL_W + 1)'(frame_peak_q);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				quo_q <= pop_frame.square_sum;
				divisor_q <= pop_frame.count;
				frame_peak_q <= pop_frame.peak;
				overlong_q <= pop_frame.overlong;
				rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= rem_sub[CNT_W-1:0];
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					mean_q <= (quo_next > SUM_W'(MEAN_MAX)) ? MEAN_MAX
						: quo_next[MEAN_W-1:0];
					root_q <= '0;
					bit_idx_q <= BIT_IDX_W'(ROOT_W - 1);
				end
			end
			ST_ROOT: begin
				if (trial_sq <= PROD_W'(mean_q)) begin
					root_q <= trial;
				end
				bit_idx_q <= bit_idx_q - BIT_IDX_W'(1);
			end
			ST_FIX: begin
				sq_q <= PROD_W'(root_q) * PROD_W'(root_q);
			end
			ST_ROUND: begin
				rms_new_q <= (root_rnd > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
					: root_rnd[LEVEL_W-1:0];
			end
			ST_SCALE: begin
				prod_old_q <= PROD_W'(K_RMS_OLD) * PROD_W'(smooth_rms_q);
				prod_new_q <= PROD_W'(K_RMS_NEW) * PROD_W'(rms_new_q);
				prod_peak_q <= PROD_W'(K_PEAK_DECAY) * PROD_W'(smooth_peak_q);
			end
			ST_BLEND: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_BLEND && out_free) begin
			out_rms_q <= (rms_cand > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
				: rms_cand[LEVEL_W-1:0];
			out_peak_q <= (peak_cand > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
				: peak_cand[LEVEL_W-1:0];
			out_overlong_q <= overlong_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			smooth_rms_q <= '0;
			smooth_peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_idx_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_BLEND;
				ST_BLEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						smooth_rms_q <= (rms_cand > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
							: rms_cand[LEVEL_W-1:0];
						smooth_peak_q <= (peak_cand > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
							: peak_cand[LEVEL_W-1:0];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_BLEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (meter.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign meter.valid = out_valid_q;
	assign meter.level_rms = out_rms_q;
	assign meter.level_peak = out_peak_q;
	assign meter.frame_overlong = out_overlong_q;

endmodule

>>> design/frame_rms_peak_meter.sv
// frame rms / peak level meter
// throughput: one sample item per cycle while the queue has room; root, smoothing once per frame
// a frame-end item reaches its result through the queue, a 43-step divide and a 16-step root
// the per-frame unit takes a new frame only when idle, so it can pace the input; queue of two
// reset: arst_n asynchronous, active low, clears accumulators, smoothed levels and handshakes
module frame_rms_peak_meter (
	input  logic clk,
	input  logic arst_n,
	fpm_in_if.sink     audio,
	fpm_out_if.source  meter
);
	import fpm_pkg::*;

	// front to queue
	logic       push_valid;
	logic       push_ready;
	fpm_frame_t push_frame;

	// queue to back
	logic       pop_valid;
	logic       pop_ready;
	fpm_frame_t pop_frame;

	// front: magnitude, square and peak per sample, frame record on frame end
	fpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.audio      (audio),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame)
	);

	// short frame queue, lets the front keep taking samples while the back is busy
	fpm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_frame  (pop_frame)
	);

	// back: mean by serial divide, root bit by bit, then smoothing and decay
	fpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_frame (pop_frame),
		.meter     (meter)
	);

`ifndef SYNTHESIS
	// the front only pushes a frame when the queue has room
	assert property (@(posedge clk) disable iff (!arst_n) push_valid |-> push_ready)
		else $error("frame pushed into a full queue");

	// every queued frame has counted between one and the limit of samples
	assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> (pop_frame.count != '0) && (pop_frame.count <= CNT_W'(MAX_FRAME)))
		else $error("queued frame with a bad sample count");

	// an overlong mark means the count stopped at the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_frame.overlong) |-> (pop_frame.count == CNT_W'(MAX_FRAME)))
		else $error("overlong frame without a full count");

	// levels never pass full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		meter.valid |-> ((17'(meter.level_rms) <= FULL_SCALE)
			&& (17'(meter.level_peak) <= FULL_SCALE)))
		else $error("level above full scale");
`endif

endmodule
